@@ sv/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the protobuf field extractor: parse phases,
// error codes and the job descriptor that goes from the parser to the result
// sequencer.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int MAX_VARINT_BYTES_DEF = 8;
    localparam int COUNT_BITS_DEF       = 8;
    localparam int JOB_DEPTH_DEF        = 4;

    localparam logic [7:0] TARGET_RESET = 8'd1;

    // Parse phase of the current message
    typedef enum logic [2:0] {
        PH_TAG,
        PH_VARINT,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    // Error codes on the final result beat
    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_TRUNC     = 3'd1,
        ERR_VARINT    = 3'd2,
        ERR_LENGTH    = 3'd3,
        ERR_NOT_FOUND = 3'd4
    } err_t;

    // Work for the result sequencer caused by one input byte:
    // ndata value bytes from data (LSB first), then an optional tail beat.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  ndata;
        logic        data_last;  // final data beat carries last
        logic [7:0]  vlen;
        logic [7:0]  consumed;
        logic        tail;       // closing beat without a value byte
        err_t        err;
    } job_t;

endpackage

@@ sv/pfe_front.sv @@
// ----------------------------------------------------------------------------
// pfe_front
// Byte parser: walks tags, varints, lengths and payloads one valid byte per
// cycle and turns every byte that causes results into one job descriptor.
// ----------------------------------------------------------------------------
module pfe_front
    import pfe_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
    parameter int COUNT_BITS       = COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] target_field,
    input  logic       byte_valid,
    input  logic [7:0] in_byte,
    input  logic       end_of_message,
    output logic       job_push,
    output job_t       job
);

    localparam int AW = 7 * MAX_VARINT_BYTES;
    localparam int CW = $clog2(MAX_VARINT_BYTES + 1);

    phase_t                phase_reg, phase_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  match_reg, match_next;
    logic [7:0]            rem_reg, rem_next;
    logic [7:0]            plen_reg, plen_next;
    logic [COUNT_BITS-1:0] bc_reg, bc_next;

    logic [AW-1:0]         acc_new;
    logic [CW-1:0]         cnt_inc;
    logic [63:0]           v64;
    logic [7:0]            rem_dec;
    logic [16:0]           bc_ext;
    logic                  tag_match;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            match_reg <= 1'b0;
            rem_reg   <= '0;
            plen_reg  <= '0;
            bc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            match_reg <= match_next;
            rem_reg   <= rem_next;
            plen_reg  <= plen_next;
            bc_reg    <= bc_next;
        end
    end

    // Varint accumulation: drop the 7 data bits in at the current group
    always_comb
    begin
        acc_new = acc_reg;
        for (int i = 0; i < MAX_VARINT_BYTES; i++)
        begin
            if (cnt_reg == CW'(i))
            begin
                acc_new[7*i +: 7] = in_byte[6:0];
            end
        end
    end

    assign cnt_inc   = cnt_reg + CW'(1);
    assign v64       = 64'(acc_new);
    assign rem_dec   = (rem_reg != 8'd0) ? rem_reg - 8'd1 : rem_reg;
    assign tag_match = (v64[63:11] == '0) && (v64[10:3] == target_field);

    // Next state and job
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        match_next = match_reg;
        rem_next   = rem_reg;
        plen_next  = plen_reg;
        bc_next    = bc_reg;
        job        = '0;
        job.err    = ERR_OK;
        job_push   = 1'b0;

        // saturating byte count, shown capped at 255
        bc_ext = 17'(bc_reg);
        if (bc_reg != '1)
        begin
            bc_ext = 17'(bc_reg) + 17'd1;
        end
        job.consumed = (bc_ext > 17'd255) ? 8'hff : bc_ext[7:0];

        if (byte_valid)
        begin
            if (phase_reg == PH_DONE)
            begin
                // rest of the message is ignored
                if (end_of_message)
                begin
                    phase_next = PH_TAG;
                end
            end
            else
            begin
                bc_next = bc_ext[COUNT_BITS-1:0];
                case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        rem_next = rem_dec;
                        if (match_reg)
                        begin
                            job.data      = 64'(in_byte);
                            job.ndata     = 4'd1;
                            job.data_last = (rem_dec == 8'd0);
                            job.vlen      = plen_reg;
                        end
                        if (rem_dec == 8'd0)
                        begin
                            phase_next = match_reg ? PH_DONE : PH_TAG;
                        end
                    end
                    default:
                    begin
                        if (in_byte[7])
                        begin
                            // continuation byte
                            acc_next = acc_new;
                            cnt_next = cnt_inc;
                            if (cnt_inc >= CW'(MAX_VARINT_BYTES))
                            begin
                                job.tail   = 1'b1;
                                job.err    = ERR_VARINT;
                                phase_next = PH_DONE;
                            end
                        end
                        else
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            case (phase_reg)
                                PH_TAG:
                                begin
                                    match_next = tag_match;
                                    case (v64[2:0])
                                        3'd0:    phase_next = PH_VARINT;
                                        3'd1:
                                        begin
                                            plen_next  = 8'd8;
                                            rem_next   = 8'd8;
                                            phase_next = PH_PAYLOAD;
                                        end
                                        3'd5:
                                        begin
                                            plen_next  = 8'd4;
                                            rem_next   = 8'd4;
                                            phase_next = PH_PAYLOAD;
                                        end
                                        3'd2:    phase_next = PH_LENGTH;
                                        default:
                                        begin
                                            // groups and unused types: no payload
                                            if (tag_match)
                                            begin
                                                job.tail   = 1'b1;
                                                phase_next = PH_DONE;
                                            end
                                        end
                                    endcase
                                end
                                PH_VARINT:
                                begin
                                    if (match_reg)
                                    begin
                                        if (v64[63:32] != '0)
                                            job.ndata = 4'd8;
                                        else if (v64[31:16] != '0)
                                            job.ndata = 4'd4;
                                        else if (v64[15:8] != '0)
                                            job.ndata = 4'd2;
                                        else
                                            job.ndata = 4'd1;
                                        job.data      = v64;
                                        job.data_last = 1'b1;
                                        job.vlen      = 8'(job.ndata);
                                        plen_next     = 8'(job.ndata);
                                        phase_next    = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_TAG;
                                    end
                                end
                                default:
                                begin
                                    // length of a length-delimited field
                                    if (v64[63:8] != '0)
                                    begin
                                        job.tail   = 1'b1;
                                        job.err    = ERR_LENGTH;
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        plen_next = v64[7:0];
                                        rem_next  = v64[7:0];
                                        if (v64[7:0] != 8'd0)
                                        begin
                                            phase_next = PH_PAYLOAD;
                                        end
                                        else if (match_reg)
                                        begin
                                            job.tail   = 1'b1;
                                            phase_next = PH_DONE;
                                        end
                                        else
                                        begin
                                            phase_next = PH_TAG;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                endcase

                // message ends before the target is done
                if (end_of_message && (phase_next != PH_DONE))
                begin
                    job.tail = 1'b1;
                    job.err  = ((phase_next == PH_TAG) && (cnt_next == '0)) ?
                               ERR_NOT_FOUND : ERR_TRUNC;
                end
                job_push = (job.ndata != 4'd0) || job.tail;
            end

            // new message starts clean
            if (end_of_message)
            begin
                phase_next = PH_TAG;
                acc_next   = '0;
                cnt_next   = '0;
                match_next = 1'b0;
                rem_next   = '0;
                plen_next  = '0;
                bc_next    = '0;
            end
        end
    end

endmodule

@@ sv/pfe_job_fifo.sv @@
// ----------------------------------------------------------------------------
// pfe_job_fifo
// Short job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module pfe_job_fifo
    import pfe_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    input  logic rd_en,
    output job_t rd_job,
    output logic not_empty,
    output logic full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == NW'(DEPTH));
    assign rd_job    = mem[rp_reg];

    // Pointer and fill count
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (do_rd)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_job;
        end
    end

endmodule

@@ sv/pfe_back.sv @@
// ----------------------------------------------------------------------------
// pfe_back
// Result sequencer: expands each job into result beats, one per cycle while
// pop keeps up, into a registered output stage.
// ----------------------------------------------------------------------------
module pfe_back
    import pfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head_job,
    input  logic       head_valid,
    output logic       head_take,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic       has_byte,
    output logic       last,
    output logic [7:0] value_length,
    output logic [7:0] consumed,
    output logic [2:0] error_code
);

    job_t       job_reg, job_next;
    logic       busy_reg, busy_next;
    logic       ov_reg, ov_next;
    logic [7:0] data_reg;
    logic       has_reg;
    logic       last_reg;
    logic [7:0] vlen_reg;
    logic [7:0] cons_reg;
    err_t       err_reg;

    logic       out_ready;
    logic       beat;
    logic       beat_final;
    logic [7:0] b_data;
    logic       b_has;
    logic       b_last;
    logic [7:0] b_vlen;
    logic [7:0] b_cons;
    err_t       b_err;

    assign out_ready = !ov_reg || pop;
    assign beat      = busy_reg && out_ready;

    // Beat built from the current job
    always_comb
    begin
        b_data     = 8'd0;
        b_has      = 1'b0;
        b_last     = 1'b0;
        b_vlen     = 8'd0;
        b_cons     = 8'd0;
        b_err      = ERR_OK;
        beat_final = 1'b1;
        if (job_reg.ndata != 4'd0)
        begin
            b_data     = job_reg.data[7:0];
            b_has      = 1'b1;
            b_last     = job_reg.data_last && (job_reg.ndata == 4'd1);
            beat_final = (job_reg.ndata == 4'd1) && !job_reg.tail;
            if (b_last)
            begin
                b_vlen = job_reg.vlen;
                b_cons = job_reg.consumed;
            end
        end
        else
        begin
            b_last = 1'b1;
            b_cons = job_reg.consumed;
            b_err  = job_reg.err;
        end
    end

    // Job register: advance a byte per beat, reload at the end
    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        head_take = 1'b0;
        if (beat)
        begin
            job_next.data  = {8'd0, job_reg.data[63:8]};
            job_next.ndata = (job_reg.ndata != 4'd0) ? job_reg.ndata - 4'd1 : 4'd0;
        end
        if (!busy_reg || (beat && beat_final))
        begin
            head_take = head_valid;
            busy_next = head_valid;
            if (head_valid)
            begin
                job_next = head_job;
            end
        end
        ov_next = beat ? 1'b1 : (pop ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (beat)
        begin
            data_reg <= b_data;
            has_reg  <= b_has;
            last_reg <= b_last;
            vlen_reg <= b_vlen;
            cons_reg <= b_cons;
            err_reg  <= b_err;
        end
    end

    assign empty        = !ov_reg;
    assign data_byte    = data_reg;
    assign has_byte     = has_reg;
    assign last         = last_reg;
    assign value_length = vlen_reg;
    assign consumed     = cons_reg;
    assign error_code   = err_reg;

endmodule

@@ sv/protobuf_field_extractor.sv @@
// ----------------------------------------------------------------------------
// protobuf_field_extractor
// Pulls the value of one field out of a protobuf-encoded byte stream.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock while full is low. A parser
// handles each byte in its cycle and posts the results it causes as one job
// into a JOB_DEPTH-deep queue; a sequencer drains that queue one result
// beat per clock, while pop keeps up, into an output register. Payload bytes
// therefore stream through at one per cycle. A matched varint gives 1, 2, 4
// or 8 beats from a single byte, so input keeps flowing until the job queue
// fills; full drops again as the sequencer works those beats off. A write
// to target_field takes effect at the next tag.
module protobuf_field_extractor
    import pfe_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int JOB_DEPTH        = JOB_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       target_field_we,
    input  logic [7:0] target_field,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic       has_byte,
    output logic       last,
    output logic [7:0] value_length,
    output logic [7:0] consumed,
    output logic [2:0] error_code
);

    logic [7:0] target_reg;
    logic       accept;
    logic       job_push;
    job_t       job;
    job_t       head_job;
    logic       head_valid;
    logic       head_take;

    // Target field register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (target_field_we)
        begin
            target_reg <= target_field;
        end
    end

    assign accept = push && !full;

    pfe_front #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
        .COUNT_BITS       (COUNT_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .target_field   (target_reg),
        .byte_valid     (accept),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .job_push       (job_push),
        .job            (job)
    );

    pfe_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_push),
        .wr_job    (job),
        .rd_en     (head_take),
        .rd_job    (head_job),
        .not_empty (head_valid),
        .full      (full)
    );

    pfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .head_valid   (head_valid),
        .head_take    (head_take),
        .empty        (empty),
        .pop          (pop),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .last         (last),
        .value_length (value_length),
        .consumed     (consumed),
        .error_code   (error_code)
    );

endmodule

@@ tb/sv/protobuf_field_extractor_test.sv @@
// ----------------------------------------------------------------------------
// protobuf_field_extractor_test
// Self-checking bench for the protobuf field extractor. Encoded messages,
// mostly well-formed with random content plus cut, oversized, overlong and
// noise variants, go in one byte per beat. A built-in decoder of the wire
// format predicts the result beats, and a scoreboard checks each popped beat
// field by field. Both handshakes idle at random, and the target field
// register is rewritten between messages.
// ----------------------------------------------------------------------------
import pfe_pkg::*;

// Protobuf wire types
typedef enum logic [2:0] {
    WT_VARINT,
    WT_FIXED64,
    WT_LEN,
    WT_GROUP_START,
    WT_GROUP_END,
    WT_FIXED32,
    WT_RSVD6,
    WT_RSVD7
} wire_t;

// One result beat
typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic [7:0] vlen;
    logic [7:0] cons;
    err_t       err;
} beat_t;

// Wire-format decoder plus the queue of beats it predicts
class field_scoreboard;
    localparam int COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;

    beat_t       expected_q[$];
    int          failures = 0;
    logic [7:0]  target = TARGET_RESET;

    // decoder state for the message in flight
    phase_t      ph;
    logic [63:0] acc;
    int          vcount;
    wire_t       wtype;
    bit          hit;
    int          remain;
    int          plen;
    int          count;

    function new();
        clear_message();
    endfunction

    function void clear_message();
        ph     = PH_TAG;
        acc    = '0;
        vcount = 0;
        wtype  = WT_VARINT;
        hit    = 1'b0;
        remain = 0;
        plen   = 0;
        count  = 0;
    endfunction

    function void next_field();
        ph     = PH_TAG;
        acc    = '0;
        vcount = 0;
    endfunction

    // length, byte count and error only ride on the closing beat
    function void emit(logic [7:0] d, bit h, bit l, int vl, err_t e);
        beat_t x;
        x.data = d;
        x.has  = h;
        x.last = l;
        x.vlen = l ? 8'(vl) : 8'd0;
        x.cons = l ? 8'(count > 255 ? 255 : count) : 8'd0;
        x.err  = l ? e : ERR_OK;
        expected_q.push_back(x);
    endfunction

    function void close_out(err_t e);
        emit(8'd0, 1'b0, 1'b1, 0, e);
        ph = PH_DONE;
    endfunction

    // Returns 1 when the byte is parsed, 0 when it is skipped after the result
    function bit note_byte(logic [7:0] b, bit eom);
        logic [63:0] v;
        int          len;
        int          i;
        if (ph == PH_DONE) begin
            if (eom)
                clear_message();
            return 1'b0;
        end
        if (count < COUNT_MAX)
            count++;

        if (ph == PH_PAYLOAD) begin
            if (remain > 0)
                remain--;
            if (hit)
                emit(b, 1'b1, remain == 0, plen, ERR_OK);
            if (remain == 0) begin
                if (hit)
                    ph = PH_DONE;
                else
                    next_field();
            end
        end
        else begin
            if (vcount < MAX_VARINT_BYTES_DEF)
                acc |= 64'(b[6:0]) << (7 * vcount);
            vcount++;
            if (b[7]) begin
                if (vcount >= MAX_VARINT_BYTES_DEF)
                    close_out(ERR_VARINT);
            end
            else begin
                v      = acc;
                acc    = '0;
                vcount = 0;
                if (ph == PH_TAG) begin
                    wtype = wire_t'(v[2:0]);
                    hit   = (v >> 3) == 64'(target);
                    case (wtype)
                        WT_VARINT: ph = PH_VARINT;
                        WT_LEN:    ph = PH_LENGTH;
                        WT_FIXED64, WT_FIXED32:
                        begin
                            plen   = (wtype == WT_FIXED64) ? 8 : 4;
                            remain = plen;
                            ph     = PH_PAYLOAD;
                        end
                        default:
                        begin
                            // groups and reserved types carry nothing
                            if (hit) begin
                                emit(8'd0, 1'b0, 1'b1, 0, ERR_OK);
                                ph = PH_DONE;
                            end
                            else
                                next_field();
                        end
                    endcase
                end
                else if (ph == PH_VARINT) begin
                    if (hit) begin
                        if (v[63:32] != 0)
                            len = 8;
                        else if (v > 64'hffff)
                            len = 4;
                        else if (v > 64'hff)
                            len = 2;
                        else
                            len = 1;
                        plen = len;
                        for (i = 0; i < len; i++)
                            emit(v[8*i +: 8], 1'b1, i == len - 1, len, ERR_OK);
                        ph = PH_DONE;
                    end
                    else
                        next_field();
                end
                else begin
                    // length prefix
                    if (v > 64'hff)
                        close_out(ERR_LENGTH);
                    else begin
                        plen   = int'(v[7:0]);
                        remain = plen;
                        if (plen != 0)
                            ph = PH_PAYLOAD;
                        else if (hit) begin
                            emit(8'd0, 1'b0, 1'b1, 0, ERR_OK);
                            ph = PH_DONE;
                        end
                        else
                            next_field();
                    end
                end
            end
        end

        if (eom) begin
            if (ph != PH_DONE)
                close_out((ph == PH_TAG && vcount == 0) ? ERR_NOT_FOUND : ERR_TRUNC);
            clear_message();
        end
        return 1'b1;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    function void check_beat(beat_t got);
        beat_t want;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: data_byte %0h", got.data);
            failures++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("data_byte", want.data, got.data);
        compare_field("has_byte", 8'(want.has), 8'(got.has));
        compare_field("last", 8'(want.last), 8'(got.last));
        compare_field("value_length", want.vlen, got.vlen);
        compare_field("consumed", want.cons, got.cons);
        compare_field("error_code", 8'(want.err), 8'(got.err));
    endfunction
endclass

module protobuf_field_extractor_test;

    localparam int GAP_PCT      = 30;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 340;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       target_field_we = 1'b0;
    logic [7:0] target_field    = TARGET_RESET;
    logic       push            = 1'b0;
    logic [7:0] in_byte         = 8'd0;
    logic       end_of_message  = 1'b0;
    logic       pop             = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    logic [7:0] value_length;
    logic [7:0] consumed;
    logic [2:0] error_code;

    field_scoreboard sb;
    logic [7:0]      msg[$];
    bit              calm = 1'b0;
    int              live_bytes = 0;
    int              quiet;

    protobuf_field_extractor dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .target_field_we (target_field_we),
        .target_field    (target_field),
        .push            (push),
        .full            (full),
        .in_byte         (in_byte),
        .end_of_message  (end_of_message),
        .empty           (empty),
        .pop             (pop),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .last            (last),
        .value_length    (value_length),
        .consumed        (consumed),
        .error_code      (error_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < GAP_PCT);
    endfunction

    // ---------------- message construction ----------------

    function automatic void add_varint(logic [63:0] v);
        do
        begin
            msg.push_back({v[63:7] != 0, v[6:0]});
            v = v >> 7;
        end
        while (v != 0);
    endfunction

    function automatic void add_tag(logic [63:0] fnum, wire_t wt);
        add_varint({fnum[60:0], wt});
    endfunction

    // spread over the 1, 2, 4 and 8 byte value forms
    function automatic logic [63:0] rand_value();
        case ($urandom_range(4))
            0: return 64'($urandom_range(255));
            1: return 64'($urandom_range(65535, 256));
            2: return {32'd0, $urandom} | 64'h1_0000;
            3: return {8'd0, (24'($urandom) | 24'h1), 32'($urandom)};
            default:
            begin
                case ($urandom_range(7))
                    0: return 64'd0;
                    1: return 64'hff;
                    2: return 64'h100;
                    3: return 64'hffff;
                    4: return 64'h1_0000;
                    5: return 64'hffff_ffff;
                    6: return 64'h1_0000_0000;
                    default: return 64'h00ff_ffff_ffff_ffff;
                endcase
            end
        endcase
    endfunction

    function automatic wire_t rand_wire();
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(3))
                0: return WT_VARINT;
                1: return WT_FIXED64;
                2: return WT_LEN;
                default: return WT_FIXED32;
            endcase
        end
        // groups and reserved types
        case ($urandom_range(3))
            0: return WT_GROUP_START;
            1: return WT_GROUP_END;
            2: return WT_RSVD6;
            default: return WT_RSVD7;
        endcase
    endfunction

    // field numbers that must not match, some sharing the target's low byte
    function automatic logic [63:0] other_field(logic [7:0] t);
        logic [63:0] f;
        case ($urandom_range(9))
            0: f = {48'd0, 8'($urandom_range(255, 1)), t};
            1: f = 64'($urandom);
            default:
            begin
                f = 64'($urandom_range(300));
                if (f == 64'(t))
                    f = f + 1;
            end
        endcase
        return f;
    endfunction

    function automatic void add_field(logic [63:0] fnum);
        wire_t wt;
        int    len;
        wt = rand_wire();
        add_tag(fnum, wt);
        case (wt)
            WT_VARINT:  add_varint(rand_value());
            WT_FIXED64: repeat (8) msg.push_back(8'($urandom));
            WT_FIXED32: repeat (4) msg.push_back(8'($urandom));
            WT_LEN:
            begin
                len = ($urandom_range(24) == 0) ? $urandom_range(255, 200)
                                                : $urandom_range(12);
                add_varint(64'(len));
                repeat (len) msg.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    function automatic void build_message(logic [7:0] t);
        int          mode;
        int          nlead;
        int          i;
        logic [63:0] fnum;
        mode  = $urandom_range(99);
        nlead = $urandom_range(2);
        fnum  = $urandom_range(1) ? 64'(t) : other_field(t);
        for (i = 0; i < nlead; i++)
            add_field(other_field(t));
        if (mode < 70) begin
            // well-formed, target present three times in four
            if ($urandom_range(3) != 0) begin
                add_field(64'(t));
                if ($urandom_range(1))
                    add_field(other_field(t));
            end
            else
                add_field(other_field(t));
        end
        else if (mode < 78) begin
            // cut short somewhere inside, or left whole
            add_field(64'(t));
            repeat ($urandom_range(msg.size() - 1))
                void'(msg.pop_back());
        end
        else if (mode < 85) begin
            // length prefix above 255
            add_tag(fnum, WT_LEN);
            add_varint(64'($urandom_range(2000, 256)));
            repeat ($urandom_range(4))
                msg.push_back(8'($urandom));
        end
        else if (mode < 92) begin
            // varint that never ends within the byte limit
            if ($urandom_range(1))
                add_tag(fnum, WT_VARINT);
            repeat ($urandom_range(11, 8))
                msg.push_back(8'h80 | 8'($urandom));
        end
        else begin
            msg.delete();
            repeat ($urandom_range(12, 1))
                msg.push_back(8'($urandom));
        end
    endfunction

    // ---------------- input side ----------------

    // one beat: idle at random, then hold until accepted
    task automatic send_byte(logic [7:0] b, bit eom);
        while (take_gap())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        in_byte        <= b;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (full);
        void'(sb.note_byte(b, eom));
        live_bytes++;
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
        msg.delete();
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write only once the block has gone quiet
    task automatic write_target(logic [7:0] value);
        drain();
        target_field_we <= 1'b1;
        target_field    <= value;
        @(posedge clk);
        target_field_we <= 1'b0;
        sb.target = value;
    endtask

    function automatic logic [7:0] pick_target();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            2: return TARGET_RESET;
            default: return 8'($urandom);
        endcase
    endfunction

    // ---------------- result side ----------------

    initial
    begin
        beat_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) begin
                got.data = data_byte;
                got.has  = has_byte;
                got.last = last;
                got.vlen = value_length;
                got.cons = consumed;
                got.err  = err_t'(error_code);
                sb.check_beat(got);
            end
            pop <= !take_gap();
        end
    end

    // watchdog: too long without a beat on either side
    initial
    begin
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial
    begin
        int n_msgs;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // target 1 from reset: varint 256 gives two value bytes
        msg = '{8'h08, 8'h80, 8'h02};
        send_message();
        // group start and reserved type 7 on the target: empty result
        msg = '{8'h0B};
        send_message();
        msg = '{8'h0F};
        send_message();
        // zero-length length-delimited
        msg = '{8'h12, 8'h00};
        send_message();
        // fixed32 streams raw
        msg = '{8'h0D, 8'h11, 8'h22, 8'h33, 8'h44};
        send_message();
        // target missing, message ends on a field boundary
        msg = '{8'h10, 8'h01};
        send_message();
        // message ends inside a tag
        msg = '{8'h88};
        send_message();
        // length 256 is too big
        msg = '{8'h12, 8'h80, 8'h02};
        send_message();
        // tag varint still running after eight bytes
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_message();
        // field 0, fixed64 cut after two payload bytes
        write_target(8'd0);
        msg = '{8'h01, 8'hAA, 8'h55};
        send_message();
        // field 255 needs a two-byte tag; group end
        write_target(8'd255);
        msg = '{8'hFC, 8'h0F};
        send_message();

        // random messages, target rewritten every ten
        live_bytes = 0;
        n_msgs     = 0;
        while (live_bytes < RANDOM_BYTES)
        begin
            if (n_msgs % 10 == 0)
                write_target(pick_target());
            calm = (n_msgs >= 12 && n_msgs < 24);
            build_message(sb.target);
            send_message();
            n_msgs++;
        end
        calm = 1'b0;

        drain();
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pfe_pkg.sv
sv/pfe_front.sv
sv/pfe_job_fifo.sv
sv/pfe_back.sv
sv/protobuf_field_extractor.sv
tb/sv/protobuf_field_extractor_test.sv
